/* design/lz77_hash_chain_encoder_unit_assert.svh */
`ifndef LZ77_HASH_CHAIN_ENCODER_UNIT_ASSERT_SVH
`define LZ77_HASH_CHAIN_ENCODER_UNIT_ASSERT_SVH

// same-cycle implication, checked at every clock edge outside reset
`define LZHC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define LZHC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/lzhc_pkg.sv */
package lzhc_pkg;

	localparam int WINDOW_BYTES_DEF      = 4096;
	localparam int LENGTH_LIMIT_DEF      = 16;
	localparam int SHORT_OFFSET_BITS_DEF = 8;
	localparam int SHORT_LENGTH_BITS_DEF = 2;
	localparam int LONG_OFFSET_BITS_DEF  = 12;
	localparam int LONG_LENGTH_BITS_DEF  = 4;

	localparam int POS_W       = 32;
	localparam int HASH_W      = 16;
	localparam int OFF_W       = 16;
	localparam int BYTE_W      = 8;
	localparam int VALUE_W     = 18;
	localparam int WIDTH_W     = 5;
	// widest match token over the whole parameter range
	localparam int TOK_FULL_W  = 2 + 16 + 8;
	localparam int MAX_TOKENS  = 64;
	localparam int TOKCNT_W    = 7;
	localparam int LIT_GROUP   = 8;
	localparam int LIT_HDR_W   = 4;
	localparam int MIN_MATCH   = 3;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;

	typedef struct packed {
		logic              last;
		logic [BYTE_W-1:0] data;
	} byte_beat_t;

endpackage

/* design/lzhc_ram.sv */
module lzhc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* design/lzhc_front.sv */
module lzhc_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                data_valid,
	output logic                data_stall,
	input  logic [7:0]          data_byte,
	input  logic                last_byte,
	output logic                q_valid,
	output lzhc_pkg::byte_beat_t q_beat,
	input  logic                q_pop
);

	localparam int CNT_W = lzhc_pkg::QPTR_W + 1;

	lzhc_pkg::byte_beat_t         slot_q [lzhc_pkg::QUEUE_DEPTH];
	logic [lzhc_pkg::QPTR_W-1:0]  wr_q;
	logic [lzhc_pkg::QPTR_W-1:0]  rd_q;
	logic [CNT_W-1:0]             cnt_q;
	logic                         push;
	logic                         pop;

	assign data_stall = (cnt_q == CNT_W'(lzhc_pkg::QUEUE_DEPTH));
	assign push       = data_valid && !data_stall;
	assign q_valid    = (cnt_q != '0);
	assign pop        = q_pop && q_valid;
	assign q_beat     = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= '{last: last_byte, data: data_byte};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

/* design/lzhc_engine.sv */
module lzhc_engine #(
	parameter int WINDOW_BYTES      = lzhc_pkg::WINDOW_BYTES_DEF,
	parameter int LENGTH_LIMIT      = lzhc_pkg::LENGTH_LIMIT_DEF,
	parameter int SHORT_OFFSET_BITS = lzhc_pkg::SHORT_OFFSET_BITS_DEF,
	parameter int SHORT_LENGTH_BITS = lzhc_pkg::SHORT_LENGTH_BITS_DEF,
	parameter int LONG_OFFSET_BITS  = lzhc_pkg::LONG_OFFSET_BITS_DEF,
	parameter int LONG_LENGTH_BITS  = lzhc_pkg::LONG_LENGTH_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_valid,
	input  lzhc_pkg::byte_beat_t q_beat,
	output logic                 q_pop,
	output logic                 token_valid,
	input  logic                 token_stall,
	output logic [17:0]          token_value,
	output logic [4:0]           token_width,
	output logic                 end_of_buffer
);

	localparam int POS_W     = lzhc_pkg::POS_W;
	localparam int HASH_W    = lzhc_pkg::HASH_W;
	localparam int OFF_W     = lzhc_pkg::OFF_W;
	localparam int TW        = lzhc_pkg::TOK_FULL_W;
	localparam int MATCH_MAX = LENGTH_LIMIT + 2;
	localparam int LOOKAHEAD = LENGTH_LIMIT + 4;
	localparam int RB        = $clog2(WINDOW_BYTES + LOOKAHEAD);
	localparam int LEN_W     = $clog2(MATCH_MAX + 1);
	localparam int LWIN_W    = $clog2(WINDOW_BYTES + 1);
	localparam int ENT_W     = POS_W + 1;
	localparam logic [OFF_W-1:0] LO_MASK = OFF_W'((1 << LONG_OFFSET_BITS) - 1);
	localparam logic [LEN_W-1:0] LL_MASK = LEN_W'((1 << LONG_LENGTH_BITS) - 1);
	localparam logic [4:0] W_SHORT = 5'(2 + SHORT_OFFSET_BITS + SHORT_LENGTH_BITS);
	localparam logic [4:0] W_LONG  = 5'(2 + LONG_OFFSET_BITS + LONG_LENGTH_BITS);

	typedef enum logic [4:0] {
		ST_CLEAR, ST_IDLE, ST_CHECK, ST_HASH0, ST_HASH1, ST_HASH2,
		ST_HEAD_RD, ST_HEAD_GET, ST_CAND, ST_CMP, ST_CMP_CHK,
		ST_LINK_RD, ST_LINK_GET, ST_DECIDE, ST_MATCH_EMIT,
		ST_INS_RD, ST_INS_WR, ST_LIT, ST_FL_HDR, ST_FL_BYTE, ST_FINAL
	} state_t;

	state_t                state_q, ret_q;
	logic [POS_W-1:0]      rcv_q, pos_q, cand_q, hash_p_q, ins_p_q;
	logic [LWIN_W-1:0]     lwin_q;
	logic [3:0]            pend_q;
	logic [2:0]            fl_k_q;
	logic                  at_end_q, ok_q, ins_mode_q, is_match_q;
	logic [HASH_W-1:0]     hash_q, clr_q;
	logic [7:0]            b0_q, b1_q, byte_i_q;
	logic [LEN_W-1:0]      limit_q, j_q, best_len_q, c_q, ins_left_q;
	logic [OFF_W-1:0]      best_off_q;
	logic [lzhc_pkg::TOKCNT_W-1:0] tokcnt_q;
	logic [7:0]            pend_bytes_q [lzhc_pkg::LIT_GROUP];
	logic [TW-1:0]         hold_v_q;
	logic [4:0]            hold_w_q;
	logic                  hold_valid_q;
	logic [17:0]           out_v_q;
	logic [4:0]            out_w_q;
	logic                  out_eob_q, out_valid_q;

	// memory ports
	logic              hd_we, lk_we, hi_we;
	logic [HASH_W-1:0] hd_waddr;
	logic [ENT_W-1:0]  hd_wdata, hd_rdata, lk_rdata;
	logic [RB-1:0]     lk_waddr, hi_waddr, hi_raddr_a, hi_raddr_b;
	logic [7:0]        hi_rdata_a, hi_rdata_b;

	// datapath
	logic [POS_W-1:0]  avail, rem, d;
	logic [7:0]        b2;
	logic [16:0]       hash_sum;
	logic [LEN_W-1:0]  j_end, c_clamp;
	logic              tok_req, can_emit, push_go, push_keep, out_load;
	logic [TW-1:0]     tok_v, tok_short, tok_long;
	logic [4:0]        tok_w;
	logic              use_short;

	lzhc_ram #(.WIDTH(ENT_W), .DEPTH(1 << HASH_W)) u_heads (
		.clk(clk), .we(hd_we), .waddr(hd_waddr), .wdata(hd_wdata),
		.raddr(hash_q), .rdata(hd_rdata)
	);

	lzhc_ram #(.WIDTH(ENT_W), .DEPTH(1 << RB)) u_links (
		.clk(clk), .we(lk_we), .waddr(lk_waddr), .wdata(hd_rdata),
		.raddr(cand_q[RB-1:0]), .rdata(lk_rdata)
	);

	// two copies of the history give two reads a cycle
	lzhc_ram #(.WIDTH(8), .DEPTH(1 << RB)) u_hist_a (
		.clk(clk), .we(hi_we), .waddr(hi_waddr), .wdata(q_beat.data),
		.raddr(hi_raddr_a), .rdata(hi_rdata_a)
	);

	lzhc_ram #(.WIDTH(8), .DEPTH(1 << RB)) u_hist_b (
		.clk(clk), .we(hi_we), .waddr(hi_waddr), .wdata(q_beat.data),
		.raddr(hi_raddr_b), .rdata(hi_rdata_b)
	);

	assign avail = rcv_q - pos_q;
	assign rem   = rcv_q - hash_p_q;
	assign d     = pos_q - cand_q;
	assign j_end = j_q;

	always_comb begin
		q_pop      = (state_q == ST_IDLE) && q_valid;
		hi_we      = q_pop;
		hi_waddr   = rcv_q[RB-1:0];
		hi_raddr_a = hash_p_q[RB-1:0];
		hi_raddr_b = RB'(hash_p_q + 32'd1);
		case (state_q)
			ST_HASH1: hi_raddr_a = RB'(hash_p_q + 32'd2);
			ST_CMP: begin
				hi_raddr_a = RB'(cand_q + POS_W'(j_q));
				hi_raddr_b = RB'(pos_q + POS_W'(j_q));
			end
			default: ;
		endcase
		hd_we    = (state_q == ST_CLEAR) || (state_q == ST_INS_WR);
		hd_waddr = (state_q == ST_CLEAR) ? clr_q : hash_q;
		hd_wdata = (state_q == ST_CLEAR) ? '0 : {1'b1, ins_p_q};
		lk_we    = (state_q == ST_INS_WR);
		lk_waddr = ins_p_q[RB-1:0];
	end

	// third hash byte reads as zero past the end of the buffer
	assign b2       = (at_end_q && rem <= 32'd2) ? 8'd0 : hi_rdata_a;
	assign hash_sum = ({1'b0, b0_q, 8'd0} + {5'd0, b1_q, 4'd0}) ^ {9'd0, b2};

	assign c_clamp   = (best_len_q - LEN_W'(lzhc_pkg::MIN_MATCH) >= LEN_W'(LENGTH_LIMIT))
		? LEN_W'(LENGTH_LIMIT - 1) : best_len_q - LEN_W'(lzhc_pkg::MIN_MATCH);
	assign use_short = ((best_off_q >> SHORT_OFFSET_BITS) == '0)
		&& ((c_q >> SHORT_LENGTH_BITS) == '0);
	assign tok_short = (TW'(1) << (1 + SHORT_OFFSET_BITS + SHORT_LENGTH_BITS))
		| (TW'(best_off_q) << SHORT_LENGTH_BITS) | TW'(c_q);
	assign tok_long  = (TW'(3) << (LONG_OFFSET_BITS + LONG_LENGTH_BITS))
		| (TW'(best_off_q & LO_MASK) << LONG_LENGTH_BITS) | TW'(c_q & LL_MASK);

	always_comb begin
		tok_req = 1'b0;
		tok_v   = '0;
		tok_w   = '0;
		case (state_q)
			ST_MATCH_EMIT: begin
				tok_req = 1'b1;
				tok_v   = use_short ? tok_short : tok_long;
				tok_w   = use_short ? W_SHORT : W_LONG;
			end
			ST_FL_HDR: begin
				tok_req = 1'b1;
				tok_v   = TW'(3'(pend_q - 4'd1));
				tok_w   = 5'(lzhc_pkg::LIT_HDR_W);
			end
			ST_FL_BYTE: begin
				tok_req = 1'b1;
				tok_v   = TW'(pend_bytes_q[fl_k_q]);
				tok_w   = 5'(lzhc_pkg::BYTE_W);
			end
			default: ;
		endcase
	end

	assign can_emit  = !out_valid_q || !token_stall;
	// tokens past the per-beat limit are dropped
	assign push_keep = tokcnt_q < lzhc_pkg::TOKCNT_W'(lzhc_pkg::MAX_TOKENS);
	assign push_go   = !push_keep || !hold_valid_q || can_emit;
	// held token moves to the output register this cycle
	assign out_load  = hold_valid_q
		&& ((tok_req && push_go && push_keep) || (state_q == ST_FINAL && can_emit));

	always_ff @(posedge clk) begin
		if (state_q == ST_LIT) begin
			pend_bytes_q[pend_q[2:0]] <= byte_i_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			ret_q        <= ST_CHECK;
			rcv_q        <= '0;
			pos_q        <= '0;
			cand_q       <= '0;
			hash_p_q     <= '0;
			ins_p_q      <= '0;
			lwin_q       <= '0;
			pend_q       <= '0;
			fl_k_q       <= '0;
			at_end_q     <= 1'b0;
			ok_q         <= 1'b0;
			ins_mode_q   <= 1'b0;
			is_match_q   <= 1'b0;
			hash_q       <= '0;
			clr_q        <= '0;
			b0_q         <= '0;
			b1_q         <= '0;
			byte_i_q     <= '0;
			limit_q      <= '0;
			j_q          <= '0;
			best_len_q   <= '0;
			best_off_q   <= '0;
			c_q          <= '0;
			ins_left_q   <= '0;
			tokcnt_q     <= '0;
			hold_v_q     <= '0;
			hold_w_q     <= '0;
			hold_valid_q <= 1'b0;
			out_v_q      <= '0;
			out_w_q      <= '0;
			out_eob_q    <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (out_valid_q && !token_stall && !out_load) begin
				out_valid_q <= 1'b0;
			end
			if (tok_req && push_go && push_keep) begin
				if (hold_valid_q) begin
					out_v_q     <= hold_v_q[17:0];
					out_w_q     <= hold_w_q;
					out_eob_q   <= 1'b0;
					out_valid_q <= 1'b1;
				end
				hold_v_q     <= tok_v;
				hold_w_q     <= tok_w;
				hold_valid_q <= 1'b1;
				tokcnt_q     <= tokcnt_q + 1'b1;
			end

			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == '1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (q_valid) begin
						rcv_q    <= rcv_q + 1'b1;
						at_end_q <= q_beat.last;
						tokcnt_q <= '0;
						state_q  <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					best_len_q <= '0;
					best_off_q <= '0;
					hash_p_q   <= pos_q;
					ins_mode_q <= 1'b0;
					limit_q    <= (at_end_q && avail < POS_W'(MATCH_MAX))
						? LEN_W'(avail) : LEN_W'(MATCH_MAX);
					if (at_end_q) begin
						if (avail != '0) begin
							state_q <= ST_HASH0;
						end else if (pend_q != '0) begin
							ret_q   <= ST_FINAL;
							state_q <= ST_FL_HDR;
						end else begin
							state_q <= ST_FINAL;
						end
					end else if (avail >= POS_W'(LOOKAHEAD)) begin
						state_q <= ST_HASH0;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_HASH0: state_q <= ST_HASH1;
				ST_HASH1: begin
					b0_q     <= hi_rdata_a;
					b1_q     <= (at_end_q && rem <= 32'd1) ? 8'd0 : hi_rdata_b;
					byte_i_q <= hi_rdata_a;
					state_q  <= ST_HASH2;
				end
				ST_HASH2: begin
					hash_q  <= hash_sum[HASH_W-1:0];
					state_q <= ins_mode_q ? ST_INS_RD : ST_HEAD_RD;
				end
				ST_HEAD_RD: state_q <= ST_HEAD_GET;
				ST_HEAD_GET: begin
					ok_q    <= hd_rdata[POS_W];
					cand_q  <= hd_rdata[POS_W-1:0];
					state_q <= ST_CAND;
				end
				ST_CAND: begin
					j_q <= '0;
					if (!ok_q || d == '0 || d >= POS_W'(WINDOW_BYTES)) begin
						state_q <= ST_DECIDE;
					end else if (d < POS_W'(lwin_q)) begin
						state_q <= ST_CMP;
					end else begin
						state_q <= ST_LINK_RD;
					end
				end
				ST_CMP: begin
					if (j_q >= limit_q) begin
						if (j_end > best_len_q) begin
							best_len_q <= j_end;
							best_off_q <= d[OFF_W-1:0];
						end
						state_q <= ST_LINK_RD;
					end else begin
						state_q <= ST_CMP_CHK;
					end
				end
				ST_CMP_CHK: begin
					if (hi_rdata_a == hi_rdata_b) begin
						j_q     <= j_q + 1'b1;
						state_q <= ST_CMP;
					end else begin
						if (j_end > best_len_q) begin
							best_len_q <= j_end;
							best_off_q <= d[OFF_W-1:0];
						end
						state_q <= ST_LINK_RD;
					end
				end
				ST_LINK_RD: state_q <= ST_LINK_GET;
				ST_LINK_GET: begin
					ok_q    <= lk_rdata[POS_W];
					cand_q  <= lk_rdata[POS_W-1:0];
					state_q <= ST_CAND;
				end
				ST_DECIDE: begin
					ins_p_q <= pos_q;
					if (best_len_q >= LEN_W'(lzhc_pkg::MIN_MATCH)) begin
						c_q        <= c_clamp;
						is_match_q <= 1'b1;
						if (pend_q != '0) begin
							ret_q   <= ST_MATCH_EMIT;
							state_q <= ST_FL_HDR;
						end else begin
							state_q <= ST_MATCH_EMIT;
						end
					end else begin
						is_match_q <= 1'b0;
						ins_left_q <= LEN_W'(1);
						state_q    <= ST_INS_RD;
					end
				end
				ST_MATCH_EMIT: begin
					if (push_go) begin
						ins_left_q <= c_q + LEN_W'(lzhc_pkg::MIN_MATCH);
						state_q    <= ST_INS_RD;
					end
				end
				ST_INS_RD: state_q <= ST_INS_WR;
				ST_INS_WR: begin
					if (ins_left_q == LEN_W'(1)) begin
						if (is_match_q) begin
							pos_q   <= pos_q + POS_W'(c_q) + POS_W'(lzhc_pkg::MIN_MATCH);
							state_q <= ST_CHECK;
						end else begin
							state_q <= ST_LIT;
						end
					end else begin
						ins_left_q <= ins_left_q - 1'b1;
						ins_p_q    <= ins_p_q + 1'b1;
						hash_p_q   <= ins_p_q + 1'b1;
						ins_mode_q <= 1'b1;
						state_q    <= ST_HASH0;
					end
				end
				ST_LIT: begin
					pend_q <= pend_q + 1'b1;
					pos_q  <= pos_q + 1'b1;
					if (lwin_q != LWIN_W'(WINDOW_BYTES)) begin
						lwin_q <= lwin_q + 1'b1;
					end
					if (pend_q + 4'd1 >= 4'(lzhc_pkg::LIT_GROUP)) begin
						ret_q   <= ST_CHECK;
						state_q <= ST_FL_HDR;
					end else begin
						state_q <= ST_CHECK;
					end
				end
				ST_FL_HDR: begin
					if (push_go) begin
						fl_k_q  <= '0;
						state_q <= ST_FL_BYTE;
					end
				end
				ST_FL_BYTE: begin
					if (push_go) begin
						if ({1'b0, fl_k_q} + 4'd1 == pend_q) begin
							pend_q  <= '0;
							state_q <= ret_q;
						end else begin
							fl_k_q <= fl_k_q + 1'b1;
						end
					end
				end
				ST_FINAL: begin
					if (!hold_valid_q || can_emit) begin
						if (hold_valid_q) begin
							out_v_q      <= hold_v_q[17:0];
							out_w_q      <= hold_w_q;
							out_eob_q    <= 1'b1;
							out_valid_q  <= 1'b1;
							hold_valid_q <= 1'b0;
						end
						rcv_q    <= '0;
						pos_q    <= '0;
						lwin_q   <= '0;
						pend_q   <= '0;
						at_end_q <= 1'b0;
						clr_q    <= '0;
						state_q  <= ST_CLEAR;
					end
				end
				default: state_q <= ST_CLEAR;
			endcase
		end
	end

	assign token_valid   = out_valid_q;
	assign token_value   = out_v_q;
	assign token_width   = out_w_q;
	assign end_of_buffer = out_eob_q;

endmodule

/* design/lz77_hash_chain_encoder_unit.sv */
// LZ77 hash-chain encoder: one byte per data beat in, tokens (value, width) out. A small
// byte queue feeds a sequential engine that codes one position at a time: it hashes the
// position, reads the head table, then walks the chain, comparing bytes at each candidate
// in the window until a mismatch or the length cap and reading each candidate's link, and
// then inserts the position; after a match each further covered position is hashed and
// inserted too. The history and table memories, each with one read and one write port,
// set this pace, and each chain candidate adds to the time a position takes. Tokens are
// held back by one so the last token of a buffer can carry end_of_buffer; a token thus
// leaves when the next one is made or the buffer ends. After reset and after every final
// byte the head table is swept clear, and no byte is coded during the sweep.
module lz77_hash_chain_encoder_unit #(
	parameter int WINDOW_BYTES      = lzhc_pkg::WINDOW_BYTES_DEF,
	parameter int LENGTH_LIMIT      = lzhc_pkg::LENGTH_LIMIT_DEF,
	parameter int SHORT_OFFSET_BITS = lzhc_pkg::SHORT_OFFSET_BITS_DEF,
	parameter int SHORT_LENGTH_BITS = lzhc_pkg::SHORT_LENGTH_BITS_DEF,
	parameter int LONG_OFFSET_BITS  = lzhc_pkg::LONG_OFFSET_BITS_DEF,
	parameter int LONG_LENGTH_BITS  = lzhc_pkg::LONG_LENGTH_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        data_valid,
	output logic        data_stall,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        token_valid,
	input  logic        token_stall,
	output logic [17:0] token_value,
	output logic [4:0]  token_width,
	output logic        end_of_buffer
);

	logic                 q_valid;
	logic                 q_pop;
	lzhc_pkg::byte_beat_t q_beat;

	lzhc_front u_front (
		.clk(clk), .arst_n(arst_n),
		.data_valid(data_valid), .data_stall(data_stall),
		.data_byte(data_byte), .last_byte(last_byte),
		.q_valid(q_valid), .q_beat(q_beat), .q_pop(q_pop)
	);

	lzhc_engine #(
		.WINDOW_BYTES(WINDOW_BYTES), .LENGTH_LIMIT(LENGTH_LIMIT),
		.SHORT_OFFSET_BITS(SHORT_OFFSET_BITS), .SHORT_LENGTH_BITS(SHORT_LENGTH_BITS),
		.LONG_OFFSET_BITS(LONG_OFFSET_BITS), .LONG_LENGTH_BITS(LONG_LENGTH_BITS)
	) u_engine (
		.clk(clk), .arst_n(arst_n),
		.q_valid(q_valid), .q_beat(q_beat), .q_pop(q_pop),
		.token_valid(token_valid), .token_stall(token_stall),
		.token_value(token_value), .token_width(token_width),
		.end_of_buffer(end_of_buffer)
	);

endmodule

/* design/lzhc_checker.sv */
`include "lz77_hash_chain_encoder_unit_assert.svh"

module lzhc_checker #(
	parameter logic [4:0] W_SHORT = 5'd12,
	parameter logic [4:0] W_LONG  = 5'd18
) (
	input logic        clk,
	input logic        arst_n,
	input logic        token_valid,
	input logic        token_stall,
	input logic [17:0] token_value,
	input logic [4:0]  token_width,
	input logic        end_of_buffer
);

	`LZHC_ASSERT_NEXT(a_tok_hold, clk, arst_n, token_valid && token_stall, token_valid, "token beat dropped while stalled")
	`LZHC_ASSERT_NEXT(a_tok_stable, clk, arst_n, token_valid && token_stall, $stable(token_value) && $stable(token_width) && $stable(end_of_buffer), "stalled token beat changed")
	`LZHC_ASSERT_NOW(a_tok_width, clk, arst_n, token_valid, token_width == 5'd4 || token_width == 5'd8 || token_width == W_SHORT || token_width == W_LONG, "illegal token width")
	`LZHC_ASSERT_NOW(a_lit_hdr, clk, arst_n, token_valid && token_width == 5'd4, token_value[17:3] == '0, "literal header out of range")

endmodule

bind lz77_hash_chain_encoder_unit lzhc_checker #(
	.W_SHORT(5'(2 + SHORT_OFFSET_BITS + SHORT_LENGTH_BITS)),
	.W_LONG(5'(2 + LONG_OFFSET_BITS + LONG_LENGTH_BITS))
) u_lzhc_checker (
	.clk(clk), .arst_n(arst_n),
	.token_valid(token_valid), .token_stall(token_stall),
	.token_value(token_value), .token_width(token_width),
	.end_of_buffer(end_of_buffer)
);
